/* rtl/core/rv32enc_pkg.sv */
// Shared types, constants and the opcode table of the RV32 instruction encoder.
// Used by rv32enc_encode, rv32_instruction_encoder_core and rv32enc_checker.
// No dependencies.
package rv32enc_pkg;

	localparam logic [6:0]  NUM_LISTED = 7'd66;
	localparam logic [6:0]  OP_HALT    = 7'd66;
	localparam logic [31:0] HALT_WORD  = 32'h0000_000B;

	localparam logic [1:0] ST_NORMAL = 2'd0;
	localparam logic [1:0] ST_HALT   = 2'd1;
	localparam logic [1:0] ST_UNIMPL = 2'd2;

	typedef enum logic [2:0] {
		FMT_R,
		FMT_I,
		FMT_SHAMT,
		FMT_UNARY,
		FMT_S,
		FMT_B,
		FMT_J,
		FMT_U
	} fmt_t;

	typedef struct packed {
		fmt_t        fmt;
		logic [31:0] base;
	} enc_entry_t;

	// One captured instruction together with the byte address it sits at.
	typedef struct packed {
		logic [6:0]  op;
		logic [4:0]  reg_a;
		logic [4:0]  reg_b;
		logic [4:0]  reg_c;
		logic [31:0] imm;
		logic [31:0] pc;
	} enc_item_t;

	typedef struct packed {
		logic [31:0] word;
		logic [1:0]  status;
	} enc_result_t;

	function automatic enc_entry_t enc_lookup(input logic [6:0] op);
		enc_entry_t e;
		e = '{fmt: FMT_R, base: 32'h0};
		unique case (op)
			7'd0:  e = '{FMT_R,     32'h00000033};
			7'd1:  e = '{FMT_R,     32'h40000033};
			7'd2:  e = '{FMT_R,     32'h00002033};
			7'd3:  e = '{FMT_R,     32'h00003033};
			7'd4:  e = '{FMT_R,     32'h00007033};
			7'd5:  e = '{FMT_R,     32'h00006033};
			7'd6:  e = '{FMT_R,     32'h00004033};
			7'd7:  e = '{FMT_R,     32'h00001033};
			7'd8:  e = '{FMT_R,     32'h00005033};
			7'd9:  e = '{FMT_R,     32'h40005033};
			7'd10: e = '{FMT_I,     32'h00000013};
			7'd11: e = '{FMT_I,     32'h00002013};
			7'd12: e = '{FMT_I,     32'h00003013};
			7'd13: e = '{FMT_I,     32'h00007013};
			7'd14: e = '{FMT_I,     32'h00006013};
			7'd15: e = '{FMT_I,     32'h00004013};
			7'd16: e = '{FMT_SHAMT, 32'h00001013};
			7'd17: e = '{FMT_SHAMT, 32'h00005013};
			7'd18: e = '{FMT_SHAMT, 32'h40005013};
			7'd19: e = '{FMT_I,     32'h00000003};
			7'd20: e = '{FMT_I,     32'h00004003};
			7'd21: e = '{FMT_I,     32'h00001003};
			7'd22: e = '{FMT_I,     32'h00005003};
			7'd23: e = '{FMT_I,     32'h00002003};
			7'd24: e = '{FMT_S,     32'h00000023};
			7'd25: e = '{FMT_S,     32'h00001023};
			7'd26: e = '{FMT_S,     32'h00002023};
			7'd27: e = '{FMT_B,     32'h00000063};
			7'd28: e = '{FMT_B,     32'h00005063};
			7'd29: e = '{FMT_B,     32'h00007063};
			7'd30: e = '{FMT_B,     32'h00004063};
			7'd31: e = '{FMT_B,     32'h00006063};
			7'd32: e = '{FMT_B,     32'h00001063};
			7'd33: e = '{FMT_J,     32'h0000006F};
			7'd34: e = '{FMT_I,     32'h00000067};
			7'd35: e = '{FMT_U,     32'h00000017};
			7'd36: e = '{FMT_U,     32'h00000037};
			7'd37: e = '{FMT_UNARY, 32'h60001013};
			7'd38: e = '{FMT_UNARY, 32'h60101013};
			7'd39: e = '{FMT_UNARY, 32'h60201013};
			7'd40: e = '{FMT_R,     32'h40007033};
			7'd41: e = '{FMT_R,     32'h40006033};
			7'd42: e = '{FMT_R,     32'h40004033};
			7'd43: e = '{FMT_R,     32'h0A004033};
			7'd44: e = '{FMT_R,     32'h0A006033};
			7'd45: e = '{FMT_R,     32'h0A005033};
			7'd46: e = '{FMT_R,     32'h0A007033};
			7'd47: e = '{FMT_UNARY, 32'h60401013};
			7'd48: e = '{FMT_UNARY, 32'h60501013};
			7'd49: e = '{FMT_R,     32'h28001033};
			7'd50: e = '{FMT_R,     32'h48001033};
			7'd51: e = '{FMT_R,     32'h68001033};
			7'd52: e = '{FMT_R,     32'h48005033};
			7'd53: e = '{FMT_SHAMT, 32'h28001013};
			7'd54: e = '{FMT_SHAMT, 32'h48001013};
			7'd55: e = '{FMT_SHAMT, 32'h68001013};
			7'd56: e = '{FMT_SHAMT, 32'h48005013};
			7'd57: e = '{FMT_R,     32'h60005033};
			7'd58: e = '{FMT_R,     32'h60001033};
			7'd59: e = '{FMT_SHAMT, 32'h60005013};
			7'd60: e = '{FMT_R,     32'h20002033};
			7'd61: e = '{FMT_R,     32'h20004033};
			7'd62: e = '{FMT_R,     32'h20006033};
			7'd63: e = '{FMT_UNARY, 32'h69805013};
			7'd64: e = '{FMT_UNARY, 32'h08004033};
			7'd65: e = '{FMT_UNARY, 32'h28705013};
			default: e = '{FMT_R, 32'h0};
		endcase
		return e;
	endfunction

endpackage

/* rtl/core/rv32enc_encode.sv */
// Combinational field packer: turns one captured instruction into its machine word.
// Depends on rv32enc_pkg (opcode table, formats, status codes).
module rv32enc_encode (
	input  rv32enc_pkg::enc_item_t   item,
	output rv32enc_pkg::enc_result_t result
);

	rv32enc_pkg::enc_entry_t entry;
	logic [31:0] off;
	logic [31:0] fields;

	assign entry = rv32enc_pkg::enc_lookup(item.op);
	// Branch and jump targets arrive as absolute byte addresses.
	assign off   = item.imm - item.pc;

	always_comb begin
		unique case (entry.fmt)
			rv32enc_pkg::FMT_R:
				fields = {7'b0, item.reg_c, item.reg_b, 3'b0, item.reg_a, 7'b0};
			rv32enc_pkg::FMT_I:
				fields = {item.imm[11:0], item.reg_b, 3'b0, item.reg_a, 7'b0};
			rv32enc_pkg::FMT_SHAMT:
				fields = {7'b0, item.imm[4:0], item.reg_b, 3'b0, item.reg_a, 7'b0};
			rv32enc_pkg::FMT_UNARY:
				fields = {12'b0, item.reg_b, 3'b0, item.reg_a, 7'b0};
			rv32enc_pkg::FMT_S:
				fields = {item.imm[11:5], item.reg_a, item.reg_b, 3'b0, item.imm[4:0], 7'b0};
			rv32enc_pkg::FMT_B:
				fields = {off[12], off[10:5], item.reg_b, item.reg_a, 3'b0,
					off[4:1], off[11], 7'b0};
			rv32enc_pkg::FMT_J:
				fields = {off[20], off[10:1], off[11], off[19:12], item.reg_a, 7'b0};
			rv32enc_pkg::FMT_U:
				fields = {item.imm[19:0], item.reg_a, 7'b0};
			default:
				fields = 32'b0;
		endcase
	end

	always_comb begin
		if (item.op < rv32enc_pkg::NUM_LISTED) begin
			result.word   = entry.base | fields;
			result.status = rv32enc_pkg::ST_NORMAL;
		end else if (item.op == rv32enc_pkg::OP_HALT) begin
			result.word   = rv32enc_pkg::HALT_WORD;
			result.status = rv32enc_pkg::ST_HALT;
		end else begin
			result.word   = 32'b0;
			result.status = rv32enc_pkg::ST_UNIMPL;
		end
	end

endmodule

/* rtl/core/rv32_instruction_encoder_core.sv */
// Top level of the RV32 instruction encoder: input register, encoder, result register.
// Depends on rv32enc_pkg and rv32enc_encode.
//
// Usage: each input beat (in_valid/in_ready) carries one decoded instruction:
// op, reg_a, reg_b, reg_c and immediate. Each beat produces exactly one output
// beat (out_valid/out_ready) with machine_word and status, in order.
// The block tracks the instruction index; branch and JAL immediates are
// absolute byte targets converted against index*4. Halt or an unimplemented
// op ends the program and clears the index; any other op advances it by one.
// From input beat to output beat an instruction passes the input register and
// then the result register, with the table lookup, packing and offset subtract
// in between. Throughput is one beat per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its beat and the input
// register takes one more beat, if it is empty, before in_ready drops.
// Reset clears both stage valids and the index to zero.
module rv32_instruction_encoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [6:0]  op,
	input  logic [4:0]  reg_a,
	input  logic [4:0]  reg_b,
	input  logic [4:0]  reg_c,
	input  logic signed [31:0] immediate,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] machine_word,
	output logic [1:0]  status
);

	logic [29:0] index_q;
	logic        valid_s1;
	logic        valid_s2;
	rv32enc_pkg::enc_item_t   item_s1;
	rv32enc_pkg::enc_result_t result_c;
	rv32enc_pkg::enc_result_t result_s2;
	logic in_fire;
	logic adv_s2;

	assign adv_s2   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s2;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q  <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
				if (op < rv32enc_pkg::NUM_LISTED) begin
					index_q <= index_q + 30'd1;
				end else begin
					index_q <= '0;
				end
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.op    <= op;
			item_s1.reg_a <= reg_a;
			item_s1.reg_b <= reg_b;
			item_s1.reg_c <= reg_c;
			item_s1.imm   <= immediate;
			item_s1.pc    <= {index_q, 2'b00};
		end
		if (adv_s2) begin
			result_s2 <= result_c;
		end
	end

	rv32enc_encode u_encode (
		.item   (item_s1),
		.result (result_c)
	);

	assign out_valid    = valid_s2;
	assign machine_word = result_s2.word;
	assign status       = result_s2.status;

endmodule

/* rtl/core/rv32enc_checker.sv */
// Port-level checker for rv32_instruction_encoder_core, attached by bind.
// Depends on rv32enc_pkg for status codes and the halt word.
module rv32enc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] machine_word,
	input logic [1:0]  status
);

	// A stalled output beat must stay presented.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(machine_word) && $stable(status))
		else $error("output beat dropped or changed while stalled");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == rv32enc_pkg::ST_NORMAL || status == rv32enc_pkg::ST_HALT
			|| status == rv32enc_pkg::ST_UNIMPL))
		else $error("illegal status code");

	a_halt_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == rv32enc_pkg::ST_HALT |-> machine_word == rv32enc_pkg::HALT_WORD)
		else $error("halt beat without halt word");

	a_unimpl_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == rv32enc_pkg::ST_UNIMPL |-> machine_word == 32'b0)
		else $error("unimplemented beat with nonzero word");

endmodule

bind rv32_instruction_encoder_core rv32enc_checker u_rv32enc_checker (.*);
